@@ hdl/hsd_pkg.sv @@
// Shared types and constants for the Hall speed and direction estimator.
`default_nettype none
package hsd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_SCALE  = 2'd0,
    CFG_STALL_TICKS  = 2'd1,
    CFG_SECTOR_TABLE = 2'd2
  } cfg_idx_t;

  localparam logic [31:0] SPEED_SCALE_RST  = 32'd26666667;
  localparam logic [15:0] STALL_TICKS_RST  = 16'd5000;
  localparam logic [23:0] SECTOR_TABLE_RST = 24'd3226956;

  typedef enum logic [1:0] {
    DIR_INVALID = 2'd0,
    DIR_REVERSE = 2'd1,
    DIR_FORWARD = 2'd2
  } dir_t;

  // Sector steps that mean a valid move; the wrap of a six-sector ring gives +-5.
  localparam logic signed [3:0] STEP_FWD      = -4'sd1;
  localparam logic signed [3:0] STEP_FWD_WRAP = 4'sd5;
  localparam logic signed [3:0] STEP_REV      = 4'sd1;
  localparam logic signed [3:0] STEP_REV_WRAP = -4'sd5;

  localparam logic [31:0] SPEED_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_AVG,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ hdl/hsd_divider.sv @@
// Bit-serial restoring divider: (scale << FRAC_BITS) / divisor, saturated to 31 bits.
`default_nettype none
module hsd_divider #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] scale,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);
  import hsd_pkg::*;

  localparam int QW    = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  logic [QW-1:0]    dvd;
  logic [QW-1:0]    q;
  logic [31:0]      rem;
  logic [31:0]      dvsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [32:0] trial;
  logic [33:0] diff;
  logic        fits;
  logic        sat;

  // One quotient bit per cycle, dividend bits shifted in from the top.
  assign trial = {rem, dvd[QW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvsr};
  assign fits  = ~diff[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= QW'(scale) << FRAC_BITS;
      q    <= '0;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      dvd <= dvd << 1;
      q   <= {q[QW-2:0], fits};
      rem <= fits ? diff[31:0] : trial[31:0];
    end
  end

  // A zero divisor yields an all-ones quotient and saturates here as well.
  assign sat  = |q[QW-1:31];
  assign quot = sat ? SPEED_MAX : {1'b0, q[30:0]};

endmodule
`default_nettype wire

@@ hdl/hsd_direction.sv @@
// Sector lookup for both Hall codes and step direction decode.
`default_nettype none
module hsd_direction (
  input  logic [23:0]        sector_table,
  input  logic [2:0]         code,
  input  logic [2:0]         prev_code,
  output logic [2:0]         sector_now,
  output hsd_pkg::dir_t      step_dir
);
  import hsd_pkg::*;

  logic [2:0]        sector_prev;
  logic signed [3:0] step;

  assign sector_now  = 3'(sector_table >> (5'd3 * {2'b00, code}));
  assign sector_prev = 3'(sector_table >> (5'd3 * {2'b00, prev_code}));
  assign step        = $signed({1'b0, sector_now}) - $signed({1'b0, sector_prev});

  always_comb begin
    if (step == STEP_FWD || step == STEP_FWD_WRAP) begin
      step_dir = DIR_FORWARD;
    end else if (step == STEP_REV || step == STEP_REV_WRAP) begin
      step_dir = DIR_REVERSE;
    end else begin
      step_dir = DIR_INVALID;
    end
  end

endmodule
`default_nettype wire

@@ hdl/hall_speed_direction_estimator_top.sv @@
// Top level of the Hall speed and direction estimator.
//
// One input item per control tick: action (0 sample, 1 stop), hall_bits and the
// down-counting timer value. Every item gives exactly one result item.
// Both channels use valid/ready. The block takes one item at a time: in_ready is
// high while no item is in work. A finished result sits in an output register, so
// the next item is accepted while the result still waits for out_ready.
// After acceptance, a stop or a tick without a Hall edge passes through PREP and
// DONE; a tick with an edge passes through PREP, AVG, DIV and DONE, where the
// bit-serial divider produces one quotient bit per cycle of a quotient that is
// 32 + SPEED_FRAC_BITS bits wide. out_valid is registered as the item leaves DONE.
// If the receiver stalls, the finished item waits in its final state until the
// output register frees; speed, direction, idle count and flags are not updated
// before then.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and
// belong in idle periods. Reset restores the register defaults and clears all
// history: speed, intervals, direction, idle count and the sticky flags.
`default_nettype none
module hall_speed_direction_estimator_top #(
  parameter int TIMER_WIDTH     = 32,
  parameter int SPEED_FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [hsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [2:0]                       hall_bits,
  input  logic [31:0]                      timer_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               speed_est,
  output logic [1:0]                       direction,
  output logic [2:0]                       sector,
  output logic [2:0]                       hall_code,
  output logic [31:0]                      period_avg,
  output logic                             edge_now,
  output logic                             edge_mark,
  output logic                             reversal_mark
);
  import hsd_pkg::*;

  localparam logic [31:0] TMASK = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

  state_t state, state_next;

  logic [31:0] speed_scale;
  logic [15:0] stall_ticks;
  logic [23:0] sector_table;

  logic        item_action;
  logic [2:0]  item_code;
  logic [31:0] item_timer;
  logic [31:0] interval;

  logic [2:0]  prev_code;
  logic [31:0] prev_timer;
  logic [31:0] prev_interval;
  logic [31:0] avg_interval;
  logic [31:0] speed_value;
  dir_t        prev_direction;
  logic [15:0] idle_count;
  logic        edge_flag;
  logic        reversal_flag;

  logic [2:0]  code_next;
  logic [31:0] speed_next;
  dir_t        dir_next;
  logic [15:0] idle_next;
  logic        edge_flag_next;
  logic        reversal_next;
  logic        edge_now_next;

  logic        accept;
  logic        finish;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_quot;
  logic        is_edge;
  logic [32:0] avg_sum;
  logic [15:0] idle_inc;
  logic [2:0]  sector_now;
  dir_t        step_dir;

  hsd_divider #(
    .FRAC_BITS(SPEED_FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .scale  (speed_scale),
    .divisor(avg_sum[32:1]),
    .done   (div_done),
    .quot   (div_quot)
  );

  hsd_direction u_dir (
    .sector_table(sector_table),
    .code        (item_code),
    .prev_code   (prev_code),
    .sector_now  (sector_now),
    .step_dir    (step_dir)
  );

  assign accept   = in_valid && in_ready;
  assign is_edge  = !item_action && (item_code != prev_code);
  assign avg_sum  = {1'b0, interval} + {1'b0, prev_interval};
  assign idle_inc = idle_count + 16'd1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_PREP;
      S_PREP: state_next = is_edge ? S_AVG : S_DONE;
      S_AVG:  state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    finish    = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_AVG:  div_start = 1'b1;
      S_DONE: finish = !out_valid || out_ready;
      default: ;
    endcase
  end

  // Per-item history update, applied when the result is written out.
  always_comb begin
    code_next      = prev_code;
    speed_next     = speed_value;
    dir_next       = prev_direction;
    idle_next      = idle_count;
    edge_flag_next = edge_flag;
    reversal_next  = reversal_flag;
    edge_now_next  = 1'b0;
    if (item_action) begin
      speed_next     = '0;
      edge_flag_next = 1'b0;
    end else if (is_edge) begin
      case (step_dir)
        DIR_REVERSE: speed_next = 32'd0 - div_quot;
        default:     speed_next = div_quot;
      endcase
      if (step_dir != prev_direction) begin
        speed_next    = '0;
        reversal_next = 1'b1;
      end
      code_next      = item_code;
      dir_next       = step_dir;
      edge_flag_next = 1'b1;
      idle_next      = '0;
      edge_now_next  = 1'b1;
    end else begin
      idle_next = idle_inc;
      if (idle_inc > stall_ticks) begin
        speed_next = '0;
        idle_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      speed_scale    <= SPEED_SCALE_RST;
      stall_ticks    <= STALL_TICKS_RST;
      sector_table   <= SECTOR_TABLE_RST;
      prev_code      <= '0;
      prev_timer     <= '0;
      prev_interval  <= '0;
      avg_interval   <= '0;
      speed_value    <= '0;
      prev_direction <= DIR_INVALID;
      idle_count     <= '0;
      edge_flag      <= 1'b0;
      reversal_flag  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SPEED_SCALE:  speed_scale  <= cfg_data;
          CFG_STALL_TICKS:  stall_ticks  <= cfg_data[15:0];
          CFG_SECTOR_TABLE: sector_table <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (state == S_AVG) begin
        prev_timer    <= item_timer;
        prev_interval <= interval;
        avg_interval  <= avg_sum[32:1];
      end
      if (finish) begin
        prev_code      <= code_next;
        speed_value    <= speed_next;
        prev_direction <= dir_next;
        idle_count     <= idle_next;
        edge_flag      <= edge_flag_next;
        reversal_flag  <= reversal_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_action <= action;
      item_code   <= hall_bits;
      item_timer  <= timer_count & TMASK;
    end
    if (state == S_PREP) begin
      interval <= (prev_timer - item_timer) & TMASK;
    end
    if (finish) begin
      speed_est     <= $signed(speed_next);
      direction     <= dir_next;
      sector        <= sector_now;
      hall_code     <= item_code;
      period_avg    <= avg_interval;
      edge_now      <= edge_now_next;
      edge_mark     <= edge_flag_next;
      reversal_mark <= reversal_next;
    end
  end

endmodule
`default_nettype wire

@@ dv/tb_hall_speed_direction_estimator_top.sv @@
// Self-checking testbench for the Hall speed and direction estimator top level.
`timescale 1ns / 100ps

module tb_hall_speed_direction_estimator_top;
  import hsd_pkg::*;

  localparam int FRAC_BITS     = 8;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic signed [31:0] speed_est;
    dir_t               direction;
    logic [2:0]         sector;
    logic [2:0]         hall_code;
    logic [31:0]        period_avg;
    logic               edge_now;
    logic               edge_mark;
    logic               reversal_mark;
  } hall_result_t;

  // Tracks the estimator state and holds the expected result items in order.
  class hall_scoreboard;
    logic [31:0]  speed_scale;
    logic [15:0]  stall_ticks;
    logic [23:0]  sector_table;
    logic [2:0]   last_code;
    logic [31:0]  last_timer;
    logic [31:0]  last_interval;
    logic [31:0]  avg_interval;
    logic [31:0]  speed_value;
    dir_t         last_dir;
    logic [15:0]  idle_count;
    logic         edge_flag;
    logic         reversal_flag;
    hall_result_t expected_q[$];
    int           fails;
    int           checked;

    function new();
      speed_scale   = SPEED_SCALE_RST;
      stall_ticks   = STALL_TICKS_RST;
      sector_table  = SECTOR_TABLE_RST;
      last_code     = '0;
      last_timer    = '0;
      last_interval = '0;
      avg_interval  = '0;
      speed_value   = '0;
      last_dir      = DIR_INVALID;
      idle_count    = '0;
      edge_flag     = 1'b0;
      reversal_flag = 1'b0;
      fails         = 0;
      checked       = 0;
    endfunction

    function void set_config(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_SPEED_SCALE:  speed_scale  = data;
        CFG_STALL_TICKS:  stall_ticks  = data[15:0];
        CFG_SECTOR_TABLE: sector_table = data[23:0];
        default: ;
      endcase
    endfunction

    function logic [2:0] sector_at(logic [2:0] code);
      return sector_table[3*code +: 3];
    endfunction

    function logic [31:0] speed_quotient(logic [31:0] divisor);
      longint unsigned q;
      if (divisor == '0) return SPEED_MAX;
      q = (64'(speed_scale) << FRAC_BITS) / 64'(divisor);
      if (q > 64'(SPEED_MAX)) return SPEED_MAX;
      return q[31:0];
    endfunction

    function void note_item(logic act, logic [2:0] code, logic [31:0] timer);
      logic [31:0]  interval;
      logic [31:0]  mag;
      logic [32:0]  sum;
      int           diff;
      dir_t         dir;
      logic         saw_edge;
      hall_result_t r;
      saw_edge = 1'b0;
      if (act) begin
        speed_value = '0;
        edge_flag   = 1'b0;
      end else if (code != last_code) begin
        interval      = last_timer - timer;
        last_timer    = timer;
        sum           = {1'b0, interval} + {1'b0, last_interval};
        avg_interval  = sum[32:1];
        last_interval = interval;
        mag           = speed_quotient(avg_interval);
        diff = int'(sector_at(code)) - int'(sector_at(last_code));
        if (diff == int'(STEP_FWD) || diff == int'(STEP_FWD_WRAP)) begin
          dir         = DIR_FORWARD;
          speed_value = mag;
        end else if (diff == int'(STEP_REV) || diff == int'(STEP_REV_WRAP)) begin
          dir         = DIR_REVERSE;
          speed_value = -mag;
        end else begin
          dir         = DIR_INVALID;
          speed_value = mag;
        end
        // any change of direction, including the first valid step, drops speed
        if (dir != last_dir) begin
          speed_value   = '0;
          reversal_flag = 1'b1;
        end
        last_code  = code;
        last_dir   = dir;
        edge_flag  = 1'b1;
        idle_count = '0;
        saw_edge   = 1'b1;
      end else begin
        idle_count = idle_count + 16'd1;
        if (idle_count > stall_ticks) begin
          speed_value = '0;
          idle_count  = '0;
        end
      end
      r.speed_est     = speed_value;
      r.direction     = last_dir;
      r.sector        = sector_at(code);
      r.hall_code     = code;
      r.period_avg    = avg_interval;
      r.edge_now      = saw_edge;
      r.edge_mark     = edge_flag;
      r.reversal_mark = reversal_flag;
      expected_q.push_back(r);
    endfunction

    function void check_result(hall_result_t got);
      hall_result_t exp_r;
      string        bad;
      checked++;
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("ERROR: result %0d arrived with no item pending", checked);
        return;
      end
      exp_r = expected_q.pop_front();
      bad = "";
      if (got.speed_est     !== exp_r.speed_est)     bad = {bad, " speed_est"};
      if (got.direction     !== exp_r.direction)     bad = {bad, " direction"};
      if (got.sector        !== exp_r.sector)        bad = {bad, " sector"};
      if (got.hall_code     !== exp_r.hall_code)     bad = {bad, " hall_code"};
      if (got.period_avg    !== exp_r.period_avg)    bad = {bad, " period_avg"};
      if (got.edge_now      !== exp_r.edge_now)      bad = {bad, " edge_now"};
      if (got.edge_mark     !== exp_r.edge_mark)     bad = {bad, " edge_mark"};
      if (got.reversal_mark !== exp_r.reversal_mark) bad = {bad, " reversal_mark"};
      if (bad != "") begin
        fails++;
        if (fails <= MAX_REPORTS) begin
          $display("ERROR: result %0d mismatch in%s", checked, bad);
          $display("  exp spd=%0d dir=%0d sec=%0d code=%0d avg=%0d edge=%b mark=%b rev=%b",
                   exp_r.speed_est, exp_r.direction, exp_r.sector, exp_r.hall_code,
                   exp_r.period_avg, exp_r.edge_now, exp_r.edge_mark, exp_r.reversal_mark);
          $display("  got spd=%0d dir=%0d sec=%0d code=%0d avg=%0d edge=%b mark=%b rev=%b",
                   got.speed_est, got.direction, got.sector, got.hall_code,
                   got.period_avg, got.edge_now, got.edge_mark, got.reversal_mark);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  action = 1'b0;
  logic [2:0]            hall_bits = '0;
  logic [31:0]           timer_count = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [31:0]    speed_est;
  logic [1:0]            direction;
  logic [2:0]            sector;
  logic [2:0]            hall_code;
  logic [31:0]           period_avg;
  logic                  edge_now;
  logic                  edge_mark;
  logic                  reversal_mark;

  hall_scoreboard sb;
  hall_result_t   got_item;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             hold_req       = 0;
  int             hold_seen      = 0;
  int             hold_left      = 0;
  int             cycle_count    = 0;
  logic [2:0]     cur_code       = '0;
  logic [31:0]    tick_timer     = '0;
  bit             go_fwd         = 1'b1;

  hall_speed_direction_estimator_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .hall_bits     (hall_bits),
    .timer_count   (timer_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .speed_est     (speed_est),
    .direction     (direction),
    .sector        (sector),
    .hall_code     (hall_code),
    .period_avg    (period_avg),
    .edge_now      (edge_now),
    .edge_mark     (edge_mark),
    .reversal_mark (reversal_mark)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL hall_speed_direction_estimator_top");
      $finish;
    end
  end

  // Result side: check accepted items, then pick out_ready for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_item = '{speed_est, dir_t'(direction), sector, hall_code, period_avg,
                   edge_now, edge_mark, reversal_mark};
      sb.check_result(got_item);
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic act, input logic [2:0] code, input logic [31:0] timer);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    hall_bits   <= code;
    timer_count <= timer;
    do @(posedge clk); while (!in_ready);
    sb.note_item(act, code, timer);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [31:0] scale, input logic [15:0] stall,
                              input logic [23:0] tbl);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SPEED_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    cfg_index <= CFG_STALL_TICKS;
    cfg_data  <= {16'd0, stall};
    @(posedge clk);
    cfg_index <= CFG_SECTOR_TABLE;
    cfg_data  <= {8'd0, tbl};
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_config(CFG_SPEED_SCALE, scale);
    sb.set_config(CFG_STALL_TICKS, {16'd0, stall});
    sb.set_config(CFG_SECTOR_TABLE, {8'd0, tbl});
  endtask

  // Codes 1..6 form a shuffled six-sector ring; codes 0 and 7 get anything.
  function automatic logic [23:0] ring_table();
    int          ring[6];
    int          j;
    int          t;
    logic [23:0] tbl;
    for (int i = 0; i < 6; i++) ring[i] = i + 1;
    for (int i = 5; i > 0; i--) begin
      j = $urandom_range(i);
      t = ring[i];
      ring[i] = ring[j];
      ring[j] = t;
    end
    tbl = 24'($urandom);
    for (int i = 0; i < 6; i++) tbl[3*(i+1) +: 3] = 3'(ring[i]);
    return tbl;
  endfunction

  function automatic logic [2:0] step_code(logic [2:0] from, bit fwd);
    int         start;
    int         diff;
    logic [2:0] c;
    start = $urandom_range(7);
    for (int k = 0; k < 8; k++) begin
      c = 3'(start + k);
      diff = int'(sb.sector_at(c)) - int'(sb.sector_at(from));
      if (fwd && (diff == int'(STEP_FWD) || diff == int'(STEP_FWD_WRAP))) return c;
      if (!fwd && (diff == int'(STEP_REV) || diff == int'(STEP_REV_WRAP))) return c;
    end
    return 3'($urandom_range(7));
  endfunction

  function automatic logic [31:0] edge_gap();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'($urandom_range(3));
    if (r < 15) return $urandom;
    return 32'($urandom_range(4000, 1));
  endfunction

  task automatic run_random(input int count);
    int          r;
    logic        act;
    logic [2:0]  code;
    logic [31:0] timer;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) go_fwd = !go_fwd;
      r   = $urandom_range(99);
      act = 1'b0;
      if (r < 8) begin
        act   = 1'b1;
        code  = 3'($urandom_range(7));
        timer = $urandom;
      end else if (r < 15) begin
        code       = 3'($urandom_range(7));
        tick_timer = $urandom;
        timer      = tick_timer;
      end else if (r < 40) begin
        code       = cur_code;
        tick_timer = tick_timer - 32'($urandom_range(200));
        timer      = tick_timer;
      end else begin
        code       = step_code(cur_code, go_fwd);
        tick_timer = tick_timer - edge_gap();
        timer      = tick_timer;
      end
      if (!act) cur_code = code;
      send_item(act, code, timer);
    end
  endtask

  initial begin
    logic [31:0] scale;
    logic [15:0] stall;
    logic [23:0] tbl;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default registers: invalid step, zero divisor, wrap steps, reversal, stop
    write_config(SPEED_SCALE_RST, STALL_TICKS_RST, SECTOR_TABLE_RST);
    send_item(1'b0, 3'd0, 32'h0000_0000);
    send_item(1'b1, 3'd7, 32'hFFFF_FFFF);
    send_item(1'b0, 3'd3, 32'h0000_0000);
    send_item(1'b0, 3'd2, 32'hFFFF_FFF0);
    send_item(1'b0, 3'd6, 32'hFFFF_FF00);
    send_item(1'b0, 3'd6, 32'hFFFF_FE00);
    send_item(1'b0, 3'd4, 32'hFFFF_0000);
    send_item(1'b0, 3'd5, 32'hFFF0_0000);
    send_item(1'b0, 3'd1, 32'hFF00_0000);
    send_item(1'b0, 3'd3, 32'hFE00_0000);
    send_item(1'b0, 3'd1, 32'hFD00_0000);
    send_item(1'b0, 3'd5, 32'hFC00_0000);
    send_item(1'b1, 3'd0, 32'hFB00_0000);
    send_item(1'b0, 3'd5, 32'hFB00_0000);
    send_item(1'b0, 3'd7, 32'h0000_0000);
    send_item(1'b0, 3'd0, 32'h0000_0000);
    drain_results();

    // largest scale, stall at zero: idle zeroing, carry in the average, overflow
    write_config(32'hFFFF_FFFF, 16'd0, SECTOR_TABLE_RST);
    send_item(1'b0, 3'd0, 32'h0000_0000);
    send_item(1'b0, 3'd4, 32'h0000_0001);
    send_item(1'b0, 3'd5, 32'h0000_0000);
    send_item(1'b0, 3'd1, 32'hFFFF_FFFE);
    send_item(1'b0, 3'd1, 32'hFFFF_FFF0);
    drain_results();

    // zero scale and an all-zero table: every step is invalid
    write_config(32'h0000_0000, 16'd65534, 24'h00_0000);
    send_item(1'b0, 3'd2, 32'd100);
    send_item(1'b0, 3'd3, 32'd50);
    send_item(1'b0, 3'd3, 32'd40);
    drain_results();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin scale = SPEED_SCALE_RST; stall = STALL_TICKS_RST; tbl = SECTOR_TABLE_RST; end
        1: begin scale = 32'hFFFF_FFFF; stall = 16'd0; tbl = ring_table(); end
        2: begin scale = 32'h0000_0000; stall = 16'd65534; tbl = ring_table(); end
        3: begin scale = 32'($urandom_range(1000, 1)); stall = 16'($urandom_range(40));
                 tbl = 24'h FF_FFFF; end
        default: begin
          case ($urandom_range(2))
            0: scale = $urandom;
            1: scale = 32'($urandom_range(100000, 1));
            default: scale = SPEED_SCALE_RST;
          endcase
          stall = ($urandom_range(3) == 0) ? 16'd65534 : 16'($urandom_range(60));
          tbl   = ($urandom_range(3) == 0) ? 24'($urandom) : ring_table();
        end
      endcase
      write_config(scale, stall, tbl);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      if (ph == 5) begin
        // receiver holds off while items keep coming; then the sender waits it out
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        run_random(45);
        drain_results();
        run_random(50);
      end else begin
        run_random(95);
      end
      drain_results();
    end

    if (sb.fails == 0 && sb.expected_q.size() == 0)
      $display("PASS hall_speed_direction_estimator_top");
    else
      $display("FAIL hall_speed_direction_estimator_top");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/hsd_pkg.sv
hdl/hsd_divider.sv
hdl/hsd_direction.sv
hdl/hall_speed_direction_estimator_top.sv
dv/tb_hall_speed_direction_estimator_top.sv
